FILE: src/tkk_pkg.sv
package tkk_pkg;

   localparam int KEEP_DEPTH = 64;
   localparam int SLOT_W     = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
   localparam int SIZE_W     = 24;
   localparam int KIND_W     = 2;
   localparam int ID_W       = 64;
   localparam int RANK_W     = 6;
   localparam int COUNT_W    = 48;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NODE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WAY      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELATION = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic              valid;
      logic [SIZE_W-1:0] size;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
   } entry_type;

   // strict precedence: size, then kind, then signed id, all descending
   function automatic logic precedes(input entry_type a, input entry_type b);
      logic [SIZE_W+KIND_W+ID_W-1:0] key_a;
      logic [SIZE_W+KIND_W+ID_W-1:0] key_b;
      key_a = {a.size, a.kind, ~a.id[ID_W-1], a.id[ID_W-2:0]};
      key_b = {b.size, b.kind, ~b.id[ID_W-1], b.id[ID_W-2:0]};
      return key_a > key_b;
   endfunction

endpackage

FILE: src/tkk_slot.sv
module tkk_slot (
   input  logic                clock,
   input  logic                reset,
   input  logic                insert_en,
   input  tkk_pkg::entry_type  incoming,
   input  logic                prev_take,
   input  tkk_pkg::entry_type  prev_entry,
   output logic                take,
   output tkk_pkg::entry_type  entry
);
   import tkk_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign take  = !entry_ff.valid || precedes(incoming, entry_ff);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (insert_en) begin
         if (prev_take) begin
            entry_in = prev_entry;
         end else if (take) begin
            entry_in       = incoming;
            entry_in.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.size <= entry_in.size;
      entry_ff.kind <= entry_in.kind;
      entry_ff.id   <= entry_in.id;
   end

endmodule

FILE: src/top_k_largest_keeper_unit.sv
// A read item is captured in the request registers; its result and rsp_strobe come from the result registers.
// Throughput: one item per cycle; busy stays low, and the receiver cannot stall.
// An insert takes effect for any read accepted in the following cycle or later.
// The sorted list is a row of slot cells that compare and shift in parallel.
// Synchronous reset empties the list and clears the three kind counts.
module top_k_largest_keeper_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [tkk_pkg::SIZE_W-1:0]    req_record_size,
   input  logic [tkk_pkg::KIND_W-1:0]    req_record_kind,
   input  logic signed [tkk_pkg::ID_W-1:0] req_record_id,
   input  logic [tkk_pkg::RANK_W-1:0]    req_rank,
   output logic                          rsp_strobe,
   output logic                          rsp_slot_valid,
   output logic [tkk_pkg::SIZE_W-1:0]    rsp_slot_size,
   output logic [tkk_pkg::KIND_W-1:0]    rsp_slot_kind,
   output logic signed [tkk_pkg::ID_W-1:0] rsp_slot_id,
   output logic [tkk_pkg::COUNT_W-1:0]   rsp_nodes_seen,
   output logic [tkk_pkg::COUNT_W-1:0]   rsp_ways_seen,
   output logic [tkk_pkg::COUNT_W-1:0]   rsp_relations_seen
);
   import tkk_pkg::*;

   logic              req_valid_ff;
   logic              func_ff;
   entry_type         incoming_ff;
   logic [RANK_W-1:0] rank_ff;

   logic [COUNT_W-1:0] nodes_ff, nodes_in;
   logic [COUNT_W-1:0] ways_ff, ways_in;
   logic [COUNT_W-1:0] relations_ff, relations_in;

   logic               rsp_strobe_ff;
   logic               slot_valid_ff, slot_valid_in;
   logic [SIZE_W-1:0]  slot_size_ff, slot_size_in;
   logic [KIND_W-1:0]  slot_kind_ff, slot_kind_in;
   logic [ID_W-1:0]    slot_id_ff, slot_id_in;
   logic [COUNT_W-1:0] nodes_seen_ff;
   logic [COUNT_W-1:0] ways_seen_ff;
   logic [COUNT_W-1:0] relations_seen_ff;

   logic                  insert_en;
   logic                  read_en;
   logic [KEEP_DEPTH-1:0] take;
   entry_type             slot_q [KEEP_DEPTH];
   entry_type             picked;
   logic                  rank_ok;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      func_ff           <= req_func;
      incoming_ff.valid <= 1'b1;
      incoming_ff.size  <= req_record_size;
      incoming_ff.kind  <= req_record_kind;
      incoming_ff.id    <= $unsigned(req_record_id);
      rank_ff           <= req_rank;
   end

   assign insert_en = req_valid_ff && (func_ff == FUNC_INSERT)
                      && (incoming_ff.kind != KIND_NONE);
   assign read_en   = req_valid_ff && (func_ff == FUNC_READ);

   for (genvar j = 0; j < KEEP_DEPTH; j++) begin : g_slot
      if (j == 0) begin : g_head
         tkk_slot u_slot (
            .clock      (clock),
            .reset      (reset),
            .insert_en  (insert_en),
            .incoming   (incoming_ff),
            .prev_take  (1'b0),
            .prev_entry (incoming_ff),
            .take       (take[j]),
            .entry      (slot_q[j])
         );
      end else begin : g_body
         tkk_slot u_slot (
            .clock      (clock),
            .reset      (reset),
            .insert_en  (insert_en),
            .incoming   (incoming_ff),
            .prev_take  (take[j-1]),
            .prev_entry (slot_q[j-1]),
            .take       (take[j]),
            .entry      (slot_q[j])
         );
      end
   end

   // saturating per-kind counts
   always_comb begin
      nodes_in     = nodes_ff;
      ways_in      = ways_ff;
      relations_in = relations_ff;
      if (insert_en) begin
         case (incoming_ff.kind)
            KIND_NODE: begin
               if (nodes_ff != COUNT_MAX) nodes_in = nodes_ff + 1'b1;
            end
            KIND_WAY: begin
               if (ways_ff != COUNT_MAX) ways_in = ways_ff + 1'b1;
            end
            KIND_RELATION: begin
               if (relations_ff != COUNT_MAX) relations_in = relations_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign rank_ok = 32'(rank_ff) < KEEP_DEPTH;
   assign picked  = slot_q[SLOT_W'(rank_ff)];

   always_comb begin
      slot_valid_in = rank_ok && picked.valid;
      slot_size_in  = '0;
      slot_kind_in  = '0;
      slot_id_in    = '0;
      if (slot_valid_in) begin
         slot_size_in = picked.size;
         slot_kind_in = picked.kind;
         slot_id_in   = picked.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff      <= '0;
         ways_ff       <= '0;
         relations_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         nodes_ff      <= nodes_in;
         ways_ff       <= ways_in;
         relations_ff  <= relations_in;
         rsp_strobe_ff <= read_en;
      end
      if (read_en) begin
         slot_valid_ff     <= slot_valid_in;
         slot_size_ff      <= slot_size_in;
         slot_kind_ff      <= slot_kind_in;
         slot_id_ff        <= slot_id_in;
         nodes_seen_ff     <= nodes_ff;
         ways_seen_ff      <= ways_ff;
         relations_seen_ff <= relations_ff;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_slot_valid     = slot_valid_ff;
   assign rsp_slot_size      = slot_size_ff;
   assign rsp_slot_kind      = slot_kind_ff;
   assign rsp_slot_id        = $signed(slot_id_ff);
   assign rsp_nodes_seen     = nodes_seen_ff;
   assign rsp_ways_seen      = ways_seen_ff;
   assign rsp_relations_seen = relations_seen_ff;

endmodule

FILE: src/tkk_checker.sv
module tkk_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_func,
   input logic                           rsp_strobe,
   input logic                           rsp_slot_valid,
   input logic [tkk_pkg::SIZE_W-1:0]     rsp_slot_size,
   input logic [tkk_pkg::KIND_W-1:0]     rsp_slot_kind,
   input logic signed [tkk_pkg::ID_W-1:0] rsp_slot_id,
   input logic [tkk_pkg::COUNT_W-1:0]    rsp_nodes_seen
);
   import tkk_pkg::*;

   property p_strobe_has_read;
      @(posedge clock) disable iff (reset)
         rsp_strobe |-> $past(start && !busy && (req_func == FUNC_READ), 2);
   endproperty
   a_strobe_has_read: assert property (p_strobe_has_read)
      else $error("result strobe without a read item two cycles earlier");

   property p_empty_slot_zero;
      @(posedge clock) disable iff (reset)
         (rsp_strobe && !rsp_slot_valid) |->
            (rsp_slot_size == '0) && (rsp_slot_kind == '0) && (rsp_slot_id == '0);
   endproperty
   a_empty_slot_zero: assert property (p_empty_slot_zero)
      else $error("empty slot result carries nonzero fields");

   property p_valid_kind;
      @(posedge clock) disable iff (reset)
         (rsp_strobe && rsp_slot_valid) |-> (rsp_slot_kind != KIND_NONE);
   endproperty
   a_valid_kind: assert property (p_valid_kind)
      else $error("kept record has an ignored kind");

   property p_count_monotonic;
      @(posedge clock) disable iff (reset)
         (rsp_strobe && $past(rsp_strobe) && !$past(reset)) |->
            (rsp_nodes_seen >= $past(rsp_nodes_seen));
   endproperty
   a_count_monotonic: assert property (p_count_monotonic)
      else $error("node count decreased");

endmodule

bind top_k_largest_keeper_unit tkk_checker u_tkk_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_func       (req_func),
   .rsp_strobe     (rsp_strobe),
   .rsp_slot_valid (rsp_slot_valid),
   .rsp_slot_size  (rsp_slot_size),
   .rsp_slot_kind  (rsp_slot_kind),
   .rsp_slot_id    (rsp_slot_id),
   .rsp_nodes_seen (rsp_nodes_seen)
);

FILE: bench/top_k_largest_keeper_unit_tb.sv
module top_k_largest_keeper_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tkk_pkg::*;

   localparam int RANDOM_ITEMS = 1780;
   localparam int QUIET_TAIL   = 300;
   localparam int SETTLE       = 8;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic              func;
      logic [SIZE_W-1:0] size;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic [RANK_W-1:0] rank;
   } request_type;

   typedef struct packed {
      logic               valid;
      logic [SIZE_W-1:0]  size;
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    id;
      logic [COUNT_W-1:0] nodes;
      logic [COUNT_W-1:0] ways;
      logic [COUNT_W-1:0] relations;
   } report_type;

   typedef struct packed {
      request_type req;
      logic        typed;
      report_type  want;
   } directed_row_type;

   localparam report_type NO_REPORT = '0;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_func = FUNC_INSERT;
   logic [SIZE_W-1:0]      req_record_size = '0;
   logic [KIND_W-1:0]      req_record_kind = KIND_NODE;
   logic signed [ID_W-1:0] req_record_id = '0;
   logic [RANK_W-1:0]      req_rank = '0;
   logic                   rsp_strobe;
   logic                   rsp_slot_valid;
   logic [SIZE_W-1:0]      rsp_slot_size;
   logic [KIND_W-1:0]      rsp_slot_kind;
   logic signed [ID_W-1:0] rsp_slot_id;
   logic [COUNT_W-1:0]     rsp_nodes_seen;
   logic [COUNT_W-1:0]     rsp_ways_seen;
   logic [COUNT_W-1:0]     rsp_relations_seen;

   entry_type          ranked [KEEP_DEPTH];
   logic [COUNT_W-1:0] kind_tally [3];
   int                 held = 0;
   report_type         pending_reports [$];
   directed_row_type   directed_rows [$];
   int                 fail_count = 0;
   int                 stall_cycles = 0;

   top_k_largest_keeper_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (ranked[j]) ranked[j] = '0;
      foreach (kind_tally[j]) kind_tally[j] = '0;
   end

   function automatic bit outranks(input request_type r, input entry_type e);
      if (r.size != e.size) return r.size > e.size;
      if (r.kind != e.kind) return r.kind > e.kind;
      return $signed(r.id) > $signed(e.id);
   endfunction

   // apply one accepted item to the shadow list; returns 1 when a report is due
   function automatic bit track_item(input request_type r, output report_type rep);
      int slot;
      rep = NO_REPORT;
      if (r.func == FUNC_READ) begin
         if (r.rank < KEEP_DEPTH && ranked[r.rank].valid) begin
            rep.valid = 1'b1;
            rep.size  = ranked[r.rank].size;
            rep.kind  = ranked[r.rank].kind;
            rep.id    = ranked[r.rank].id;
         end
         rep.nodes     = kind_tally[KIND_NODE];
         rep.ways      = kind_tally[KIND_WAY];
         rep.relations = kind_tally[KIND_RELATION];
         return 1'b1;
      end
      if (r.kind == KIND_NONE) return 1'b0;
      if (kind_tally[r.kind] != COUNT_MAX) kind_tally[r.kind] = kind_tally[r.kind] + 1'b1;
      slot = 0;
      while (slot < KEEP_DEPTH && ranked[slot].valid && !outranks(r, ranked[slot]))
         slot++;
      if (slot < KEEP_DEPTH) begin
         for (int j = KEEP_DEPTH - 1; j > slot; j--) ranked[j] = ranked[j-1];
         ranked[slot] = '{1'b1, r.size, r.kind, r.id};
         if (held < KEEP_DEPTH) held++;
      end
      return 1'b0;
   endfunction

   function automatic request_type random_request();
      request_type r;
      logic [31:0] noise;
      int          small_id;
      int          j;
      noise  = $urandom;
      r.func = ($urandom_range(0, 9) < 4) ? FUNC_READ : FUNC_INSERT;
      r.size = noise[SIZE_W-1:0];
      r.kind = KIND_W'($urandom_range(0, 3));
      r.id   = {$urandom, $urandom};
      r.rank = RANK_W'($urandom_range(0, 63));
      if (r.func == FUNC_READ) begin
         if ($urandom_range(0, 1) == 0)
            r.rank = RANK_W'($urandom_range(0, (held > 63) ? 63 : held));
         return r;
      end
      if ($urandom_range(0, 9) == 0) r.kind = KIND_NONE;
      else r.kind = KIND_W'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.id = {$urandom, $urandom};
         4, 5, 6: begin
            small_id = $urandom_range(0, 8) - 4;
            r.id = {{32{small_id[31]}}, small_id};
         end
         default: begin
            case ($urandom_range(0, 3))
               0: r.id = 64'h8000_0000_0000_0000;
               1: r.id = 64'h7FFF_FFFF_FFFF_FFFF;
               2: r.id = '0;
               default: r.id = '1;
            endcase
         end
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            if (held > 0) begin
               j = $urandom_range(0, held - 1);
               r.size = ranked[j].size;
               if (r.kind != KIND_NONE) r.kind = ranked[j].kind;
               if ($urandom_range(0, 1) == 0) r.id = ranked[j].id;
            end
         end
         3, 4, 5, 6, 7, 8, 9: r.size = SIZE_W'($urandom_range(0, 63));
         10, 11, 12, 13, 14: r.size = noise[SIZE_W-1:0];
         default: begin
            case ($urandom_range(0, 3))
               0: r.size = '0;
               1: r.size = 24'hFF_FFFF;
               2: r.size = 24'hFF_FFFE;
               default: r.size = 24'd1;
            endcase
         end
      endcase
      return r;
   endfunction

   task automatic add_row(input request_type req, input logic typed, input report_type want);
      directed_row_type row;
      row.req       = req;
      row.typed     = typed;
      row.want      = want;
      directed_rows = {directed_rows, row};
   endtask

   task automatic post_report(input report_type rep);
      pending_reports = {pending_reports, rep};
   endtask

   // present one item and hold it until accepted
   task automatic issue(input request_type r, input int gap, input bit drain);
      if (drain && gap == 0) gap = 1;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         if (drain)
            while (pending_reports.size() != 0) @(posedge clock);
      end
      req_func        <= r.func;
      req_record_size <= r.size;
      req_record_kind <= r.kind;
      req_record_id   <= r.id;
      req_rank        <= r.rank;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s expected %0h got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            $error("result strobe with no read item outstanding");
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("slot_valid", want.valid, rsp_slot_valid);
            check_field("slot_size", want.size, rsp_slot_size);
            check_field("slot_kind", want.kind, rsp_slot_kind);
            check_field("slot_id", want.id, rsp_slot_id);
            check_field("nodes_seen", want.nodes, rsp_nodes_seen);
            check_field("ways_seen", want.ways, rsp_ways_seen);
            check_field("relations_seen", want.relations, rsp_relations_seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("top_k_largest_keeper_unit: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      directed_row_type row;
      request_type      r;
      report_type       rep;
      int               issued;
      int               gap;
      bit               drained;
      bit               idle_ok;

      add_row('{FUNC_READ, 24'd0, KIND_NODE, 64'd0, 6'd0}, 1'b1, NO_REPORT);
      add_row('{FUNC_READ, 24'hFF_FFFF, KIND_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63},
              1'b1, NO_REPORT);
      add_row('{FUNC_INSERT, 24'hFF_FFFF, KIND_RELATION, 64'h7FFF_FFFF_FFFF_FFFF, 6'd63},
              1'b0, NO_REPORT);
      add_row('{FUNC_READ, 24'd0, KIND_NODE, 64'd0, 6'd0}, 1'b1,
              '{1'b1, 24'hFF_FFFF, KIND_RELATION, 64'h7FFF_FFFF_FFFF_FFFF,
                48'd0, 48'd0, 48'd1});
      add_row('{FUNC_INSERT, 24'd0, KIND_NODE, 64'h8000_0000_0000_0000, 6'd42},
              1'b0, NO_REPORT);
      add_row('{FUNC_READ, 24'd0, KIND_NODE, 64'd0, 6'd1}, 1'b1,
              '{1'b1, 24'd0, KIND_NODE, 64'h8000_0000_0000_0000,
                48'd1, 48'd0, 48'd1});
      add_row('{FUNC_INSERT, 24'hFF_FFFF, KIND_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0},
              1'b0, NO_REPORT);
      add_row('{FUNC_READ, 24'd0, KIND_NODE, 64'd0, 6'd2}, 1'b1,
              '{1'b0, 24'd0, KIND_NODE, 64'd0, 48'd1, 48'd0, 48'd1});
      add_row('{FUNC_INSERT, 24'd100, KIND_WAY, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0},
              1'b0, NO_REPORT);
      add_row('{FUNC_INSERT, 24'd100, KIND_WAY, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0},
              1'b0, NO_REPORT);
      add_row('{FUNC_INSERT, 24'd100, KIND_WAY, 64'd0, 6'd0}, 1'b0, NO_REPORT);
      add_row('{FUNC_INSERT, 24'd100, KIND_NODE, 64'd5, 6'd0}, 1'b0, NO_REPORT);
      add_row('{FUNC_INSERT, 24'd100, KIND_RELATION, 64'hFFFF_FFFF_FFFF_FFFB, 6'd0},
              1'b0, NO_REPORT);
      add_row('{FUNC_INSERT, 24'd100, KIND_WAY, 64'h8000_0000_0000_0000, 6'd0},
              1'b0, NO_REPORT);
      for (int k = 0; k <= 8; k++)
         add_row('{FUNC_READ, 24'h5A_5A5A, KIND_RELATION, 64'hDEAD_BEEF, RANK_W'(k)},
                 1'b0, NO_REPORT);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
         issue(row.req, gap, 1'b0);
         if (track_item(row.req, rep))
            post_report(row.typed ? row.want : rep);
      end

      issued  = 0;
      drained = 1'b0;
      while (issued < RANDOM_ITEMS) begin
         r       = random_request();
         idle_ok = issued < RANDOM_ITEMS - QUIET_TAIL && (issued / 150) % 4 != 2;
         gap     = (idle_ok && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
         issue(r, gap, !drained && issued >= RANDOM_ITEMS / 2);
         if (issued >= RANDOM_ITEMS / 2) drained = 1'b1;
         if (track_item(r, rep)) post_report(rep);
         issued++;
      end
      start <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("top_k_largest_keeper_unit: match");
      end else begin
         $display("top_k_largest_keeper_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/tkk_pkg.sv
src/tkk_slot.sv
src/top_k_largest_keeper_unit.sv
src/tkk_checker.sv
bench/top_k_largest_keeper_unit_tb.sv
